// ===== hw/rtl/stfe_pkg.sv =====
// Shared types, constants and command/status structs for the slide timer fade envelope.
`default_nettype none

package stfe_pkg;

  localparam int MAX_SLIDES_DEF = 64;
  localparam int TIME_W         = 32;
  localparam int COUNT_W        = 7;
  localparam int IDX_W          = 6;
  localparam int ALPHA_W        = 16;
  localparam int FRAC_W         = 15;
  localparam int NUM_W          = 8;
  localparam int CNT_W          = 4;
  localparam int MOD_STEPS      = NUM_W;
  localparam int ALPHA_STEPS    = FRAC_W;
  localparam int OUT_W          = 24;
  localparam int CFG_IDX_W      = 2;

  localparam logic [TIME_W-1:0]  INTERVAL_RST = 32'd5000;
  localparam logic [TIME_W-1:0]  FADE_RST     = 32'd500;
  localparam logic [COUNT_W-1:0] COUNT_RST    = 7'd0;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE    = 16'h8000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INTERVAL    = 2'd0,
    CFG_IMAGE_COUNT = 2'd1,
    CFG_FADE        = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [TIME_W-1:0]  interval;
    logic [COUNT_W-1:0] image_count;
    logic [TIME_W-1:0]  fade;
  } cfg_t;

  typedef enum logic [2:0] {
    SL_HOLD,
    SL_REWIND,
    SL_START,
    SL_INC,
    SL_WRAP,
    SL_STAMP,
    SL_MOD
  } slide_op_t;

  typedef enum logic [2:0] {
    DV_IDLE,
    DV_LOAD_MOD,
    DV_LOAD_RISE,
    DV_LOAD_FALL,
    DV_STEP
  } div_op_t;

  typedef enum logic [2:0] {
    RS_HOLD,
    RS_REWIND,
    RS_ZERO,
    RS_TRANSP,
    RS_OPAQUE,
    RS_QUO
  } res_op_t;

  typedef struct packed {
    logic      capture;
    slide_op_t slide_op;
    div_op_t   div_op;
    res_op_t   res_op;
    logic      env_load;
    logic      out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic req_rewind;
    logic count_zero;
    logic fresh;
    logic adv;
    logic inc_lt;
    logic inc_eq;
    logic interval_zero;
    logic rise;
    logic fall;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/slide_timer_fade_envelope_top.sv =====
// Sequence: a rewind or a tick with no images goes from decide straight to finish; other
// ticks pass through the envelope states and, on a fade ramp, the 15-step serial divider.
// A slide advance past a lowered image count adds 8 divider steps before the envelope.
// Flow: the next request is taken only after the result enters the output register,
// so one request is in flight at a time. Reset (synchronous, active low) restores the config
// registers to their defaults, slide 0, time stamp 0, awaiting the first tick.
`default_nettype none

module slide_timer_fade_envelope_top #(
  parameter int MAX_SLIDES = stfe_pkg::MAX_SLIDES_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [stfe_pkg::TIME_W-1:0]    in_tdata,   // [31:0] now_ms
  input  wire logic                           in_tuser,   // [0] req_type
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic      [stfe_pkg::OUT_W-1:0]     out_tdata,  // [0] has_image, [6:1] slide_index,
                                                          // [22:7] alpha, [23] zero
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [stfe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [stfe_pkg::TIME_W-1:0]    cfg_data
);

  stfe_pkg::cfg_t    cfg;
  stfe_pkg::dp_cmd_t cmd;
  stfe_pkg::dp_sts_t sts;

  stfe_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  stfe_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  stfe_dp #(
    .MAX_SLIDES (MAX_SLIDES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .cmd       (cmd),
    .sts       (sts),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/stfe_cfg.sv =====
// Configuration register file: interval, image count and fade duration.
`default_nettype none

module stfe_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [stfe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [stfe_pkg::TIME_W-1:0]    cfg_data,
  output stfe_pkg::cfg_t                      cfg
);

  stfe_pkg::cfg_t cfg_r;
  stfe_pkg::cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (stfe_pkg::cfg_idx_t'(cfg_index))
        stfe_pkg::CFG_INTERVAL:    cfg_nxt.interval    = cfg_data;
        stfe_pkg::CFG_IMAGE_COUNT: cfg_nxt.image_count = cfg_data[stfe_pkg::COUNT_W-1:0];
        stfe_pkg::CFG_FADE:        cfg_nxt.fade        = cfg_data;
        default:                   cfg_nxt             = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.interval    <= stfe_pkg::INTERVAL_RST;
      cfg_r.image_count <= stfe_pkg::COUNT_RST;
      cfg_r.fade        <= stfe_pkg::FADE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/stfe_dp.sv =====
// Datapath: slide state, envelope arithmetic, serial divider and output register.
`default_nettype none

module stfe_dp #(
  parameter int MAX_SLIDES = stfe_pkg::MAX_SLIDES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire stfe_pkg::cfg_t               cfg,
  input  wire stfe_pkg::dp_cmd_t            cmd,
  output stfe_pkg::dp_sts_t                 sts,
  input  wire logic                         in_tuser,
  input  wire logic [stfe_pkg::TIME_W-1:0]  in_tdata,
  output logic      [stfe_pkg::OUT_W-1:0]   out_tdata
);

  // image_count is 7 bits, so the stored slide never needs more than 7 bits
  localparam int SLIDE_CAP = (MAX_SLIDES > 128) ? 128 : MAX_SLIDES;
  localparam int SLIDE_W   = (SLIDE_CAP < 2) ? 1 : $clog2(SLIDE_CAP);
  localparam int TW        = stfe_pkg::TIME_W;

  logic                         req_r;
  logic [TW-1:0]                now_r;
  logic [SLIDE_W-1:0]           slide_r, slide_nxt;
  logic [TW-1:0]                last_r, last_nxt;
  logic                         fresh_r, fresh_nxt;
  logic [TW-1:0]                el_r;
  logic [TW-1:0]                fade_r;
  logic [TW-1:0]                rem_r, rem_nxt;
  logic [stfe_pkg::ALPHA_W-1:0] quo_r, quo_nxt;
  logic [TW-1:0]                div_r, div_nxt;
  logic                         res_has_r, res_has_nxt;
  logic [stfe_pkg::IDX_W-1:0]   res_slide_r, res_slide_nxt;
  logic [stfe_pkg::ALPHA_W-1:0] res_alpha_r, res_alpha_nxt;
  logic [stfe_pkg::OUT_W-1:0]   out_data_r;

  logic [stfe_pkg::COUNT_W-1:0] count;
  logic [stfe_pkg::NUM_W-1:0]   count8;
  logic [stfe_pkg::NUM_W-1:0]   slide_inc;
  logic [TW-1:0]                diff;
  logic [TW-1:0]                half;
  logic [TW-1:0]                fade_sel;
  logic [TW-1:0]                el_clamp;
  logic [TW-1:0]                thr;
  logic [TW-1:0]                fall_num;
  logic [TW:0]                  r2;
  logic [TW:0]                  r_sub;
  logic                         ge;
  logic [TW-1:0]                rem_step;
  logic [stfe_pkg::ALPHA_W-1:0] quo_step;

  assign count = (32'(cfg.image_count) > 32'(MAX_SLIDES)) ? stfe_pkg::COUNT_W'(MAX_SLIDES)
                                                          : cfg.image_count;
  assign count8    = stfe_pkg::NUM_W'(count);
  assign slide_inc = stfe_pkg::NUM_W'(slide_r) + 8'd1;
  assign diff      = now_r - last_r;
  assign half      = cfg.interval >> 1;
  assign fade_sel  = (cfg.fade < half) ? cfg.fade : half;
  assign el_clamp  = (diff > cfg.interval) ? cfg.interval : diff;
  assign thr       = cfg.interval - fade_r;
  assign fall_num  = cfg.interval - el_r;

  // one restoring step: shift in the next dividend bit, subtract when it fits
  assign r2       = {rem_r, quo_r[stfe_pkg::ALPHA_W-1]};
  assign r_sub    = r2 - {1'b0, div_r};
  assign ge       = (r2 >= {1'b0, div_r});
  assign rem_step = ge ? r_sub[TW-1:0] : r2[TW-1:0];
  assign quo_step = {quo_r[stfe_pkg::ALPHA_W-2:0], ge};

  always_comb begin
    sts.req_rewind    = req_r;
    sts.count_zero    = (count == '0);
    sts.fresh         = fresh_r;
    sts.adv           = (diff >= cfg.interval);
    sts.inc_lt        = (slide_inc < count8);
    sts.inc_eq        = (slide_inc == count8);
    sts.interval_zero = (cfg.interval == '0);
    sts.rise          = (el_r < fade_r);
    sts.fall          = (el_r > thr);
  end

  always_comb begin
    slide_nxt = slide_r;
    last_nxt  = last_r;
    fresh_nxt = fresh_r;
    case (cmd.slide_op)
      stfe_pkg::SL_REWIND: begin
        slide_nxt = '0;
        last_nxt  = now_r;
        fresh_nxt = 1'b1;
      end
      stfe_pkg::SL_START: begin
        slide_nxt = '0;
        last_nxt  = now_r;
        fresh_nxt = 1'b0;
      end
      stfe_pkg::SL_INC: begin
        slide_nxt = slide_inc[SLIDE_W-1:0];
        last_nxt  = now_r;
      end
      stfe_pkg::SL_WRAP: begin
        slide_nxt = '0;
        last_nxt  = now_r;
      end
      stfe_pkg::SL_STAMP: last_nxt  = now_r;
      stfe_pkg::SL_MOD:   slide_nxt = rem_step[SLIDE_W-1:0];
      default: ;
    endcase
  end

  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    div_nxt = div_r;
    case (cmd.div_op)
      stfe_pkg::DV_LOAD_MOD: begin
        rem_nxt = '0;
        quo_nxt = {slide_inc, 8'd0};
        div_nxt = TW'(count);
      end
      stfe_pkg::DV_LOAD_RISE: begin
        rem_nxt = el_r;
        quo_nxt = '0;
        div_nxt = fade_r;
      end
      stfe_pkg::DV_LOAD_FALL: begin
        rem_nxt = fall_num;
        quo_nxt = '0;
        div_nxt = fade_r;
      end
      stfe_pkg::DV_STEP: begin
        rem_nxt = rem_step;
        quo_nxt = quo_step;
      end
      default: ;
    endcase
  end

  always_comb begin
    res_has_nxt   = res_has_r;
    res_slide_nxt = res_slide_r;
    res_alpha_nxt = res_alpha_r;
    case (cmd.res_op)
      stfe_pkg::RS_REWIND: begin
        res_has_nxt   = (count != '0);
        res_slide_nxt = '0;
        res_alpha_nxt = '0;
      end
      stfe_pkg::RS_ZERO: begin
        res_has_nxt   = 1'b0;
        res_slide_nxt = '0;
        res_alpha_nxt = '0;
      end
      stfe_pkg::RS_TRANSP: begin
        res_has_nxt   = 1'b1;
        res_slide_nxt = stfe_pkg::IDX_W'(slide_r);
        res_alpha_nxt = '0;
      end
      stfe_pkg::RS_OPAQUE: begin
        res_has_nxt   = 1'b1;
        res_slide_nxt = stfe_pkg::IDX_W'(slide_r);
        res_alpha_nxt = stfe_pkg::ALPHA_ONE;
      end
      stfe_pkg::RS_QUO: begin
        res_has_nxt   = 1'b1;
        res_slide_nxt = stfe_pkg::IDX_W'(slide_r);
        res_alpha_nxt = {1'b0, quo_step[stfe_pkg::FRAC_W-1:0]};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slide_r <= '0;
      last_r  <= '0;
      fresh_r <= 1'b1;
    end else begin
      slide_r <= slide_nxt;
      last_r  <= last_nxt;
      fresh_r <= fresh_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_tuser;
      now_r <= in_tdata;
    end
    if (cmd.env_load) begin
      el_r   <= el_clamp;
      fade_r <= fade_sel;
    end
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    div_r       <= div_nxt;
    res_has_r   <= res_has_nxt;
    res_slide_r <= res_slide_nxt;
    res_alpha_r <= res_alpha_nxt;
    if (cmd.out_load) begin
      out_data_r <= {1'b0, res_alpha_r, res_slide_r, res_has_r};
    end
  end

  assign out_tdata = out_data_r;

endmodule

`default_nettype wire

// ===== hw/rtl/stfe_ctrl.sv =====
// Controller: sequences each request through decide and output, with modulo, envelope and divide steps as needed.
`default_nettype none

module stfe_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  input  wire stfe_pkg::dp_sts_t sts,
  output stfe_pkg::dp_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_MOD,
    S_ENV_A,
    S_ENV_B,
    S_DIV,
    S_FINISH
  } state_t;

  state_t                     state_r, state_nxt;
  logic [stfe_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                       in_ready_r, in_ready_nxt;
  logic                       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    cmd.capture  = 1'b0;
    cmd.slide_op = stfe_pkg::SL_HOLD;
    cmd.div_op   = stfe_pkg::DV_IDLE;
    cmd.res_op   = stfe_pkg::RS_HOLD;
    cmd.env_load = 1'b0;
    cmd.out_load = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_ready_r) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.req_rewind) begin
          cmd.slide_op = stfe_pkg::SL_REWIND;
          cmd.res_op   = stfe_pkg::RS_REWIND;
          state_nxt    = S_FINISH;
        end else if (sts.count_zero) begin
          cmd.res_op = stfe_pkg::RS_ZERO;
          state_nxt  = S_FINISH;
        end else if (sts.fresh) begin
          cmd.slide_op = stfe_pkg::SL_START;
          state_nxt    = S_ENV_A;
        end else if (sts.adv) begin
          if (sts.inc_lt) begin
            cmd.slide_op = stfe_pkg::SL_INC;
            state_nxt    = S_ENV_A;
          end else if (sts.inc_eq) begin
            cmd.slide_op = stfe_pkg::SL_WRAP;
            state_nxt    = S_ENV_A;
          end else begin
            // stale slide beyond the count: take the remainder serially
            cmd.slide_op = stfe_pkg::SL_STAMP;
            cmd.div_op   = stfe_pkg::DV_LOAD_MOD;
            cnt_nxt      = '0;
            state_nxt    = S_MOD;
          end
        end else begin
          state_nxt = S_ENV_A;
        end
      end
      S_MOD: begin
        cmd.div_op = stfe_pkg::DV_STEP;
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == stfe_pkg::CNT_W'(stfe_pkg::MOD_STEPS - 1)) begin
          cmd.slide_op = stfe_pkg::SL_MOD;
          state_nxt    = S_ENV_A;
        end
      end
      S_ENV_A: begin
        cmd.env_load = 1'b1;
        state_nxt    = S_ENV_B;
      end
      S_ENV_B: begin
        if (sts.interval_zero) begin
          cmd.res_op = stfe_pkg::RS_TRANSP;
          state_nxt  = S_FINISH;
        end else if (sts.rise) begin
          cmd.div_op = stfe_pkg::DV_LOAD_RISE;
          cnt_nxt    = '0;
          state_nxt  = S_DIV;
        end else if (sts.fall) begin
          cmd.div_op = stfe_pkg::DV_LOAD_FALL;
          cnt_nxt    = '0;
          state_nxt  = S_DIV;
        end else begin
          cmd.res_op = stfe_pkg::RS_OPAQUE;
          state_nxt  = S_FINISH;
        end
      end
      S_DIV: begin
        cmd.div_op = stfe_pkg::DV_STEP;
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == stfe_pkg::CNT_W'(stfe_pkg::ALPHA_STEPS - 1)) begin
          cmd.res_op = stfe_pkg::RS_QUO;
          state_nxt  = S_FINISH;
        end
      end
      S_FINISH: begin
        // hold the result until the output register is free
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_ready_nxt  = (state_nxt == S_IDLE);
  assign out_valid_nxt = cmd.out_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      in_ready_r  <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      in_ready_r  <= in_ready_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = in_ready_r;
  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

// ===== hw/rtl/stfe_checker.sv =====
// Port-level checker for the slide timer fade envelope, bound to the top level.
`default_nettype none

module stfe_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_tvalid,
  input wire logic                       in_tready,
  input wire logic                       out_tvalid,
  input wire logic                       out_tready,
  input wire logic [stfe_pkg::OUT_W-1:0] out_tdata
);

  logic in_acc;
  assign in_acc = in_tvalid && in_tready;

  // a stalled result must not change
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

  // one request in flight: busy right after acceptance
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("request taken while busy");

  // without an image, index and alpha are both zero
  a_no_image_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> (out_tdata[22:1] == 22'd0))
    else $error("fields set without an image");

  // alpha never exceeds full opacity
  a_alpha_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[22] |-> (out_tdata[21:7] == 15'd0))
    else $error("alpha above full opacity");

  // the padding bit stays clear
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[23])
    else $error("padding bit set");

endmodule

bind slide_timer_fade_envelope_top stfe_checker u_stfe_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
